/* rtl/srgb_to_cie_xy_chromaticity_unit_assert.svh */
// Assertion macros used by the checker file.
`ifndef SRGB_TO_CIE_XY_CHROMATICITY_UNIT_ASSERT_SVH
`define SRGB_TO_CIE_XY_CHROMATICITY_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SXY_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srgbxy check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SXY_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srgbxy check failed");

`endif

/* rtl/srgbxy_pkg.sv */
package srgbxy_pkg;

  // Default number of fraction bits of a linearized channel.
  localparam int unsigned LinFracBitsDef = 16;
  // Widest ROM entry over the allowed range of fraction bits.
  localparam int unsigned LinMaxW = 25;
  // Quotient bits produced by the divider (results up to 131071).
  localparam int unsigned QuoBits = 17;
  localparam logic [15:0] WhiteX = 16'd20493;
  localparam logic [15:0] WhiteY = 16'd21561;
  localparam logic [15:0] ChromaMax = 16'hFFFF;

  typedef logic [15:0] coef_row_t [3];
  typedef coef_row_t coef_mat_t [3];

  // D65 sRGB to XYZ matrix in Q0.16, rows X, Y, Z.
  localparam coef_mat_t Coef = '{
    '{16'd27031, 16'd23434, 16'd11825},
    '{16'd13938, 16'd46868, 16'd4730},
    '{16'd1267,  16'd7811,  16'd62279}
  };

  typedef logic [LinMaxW-1:0] rom_t [256];

  // Q30 multiply, rounded half up.
  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // One entry of the sRGB linearization curve with f fraction bits.
  function automatic logic [LinMaxW-1:0] curve_entry(int unsigned i, int unsigned f);
    longint unsigned num, t, u, lo, hi, mid, w2, w4, v, e, top;
    num = 0;
    if (i <= 10) begin
      num = ((longint'(i) * 100) << f) + 164730;
      return LinMaxW'(num / 329460);
    end
    t = (((longint'(i) * 1000 + 14025) << 30) + 134512) / 269025;
    u = q30_mul(t, t);
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      w2 = q30_mul(mid, mid);
      w4 = q30_mul(w2, w2);
      if (q30_mul(w4, mid) <= u) lo = mid;
      else hi = mid - 1;
    end
    v = q30_mul(u, lo);
    e = (v + (64'd1 << (29 - f))) >> (30 - f);
    top = 64'd1 << f;
    return LinMaxW'((e > top) ? top : e);
  endfunction

  // Whole linearization table, built at elaboration.
  function automatic rom_t build_rom(int unsigned f);
    rom_t r;
    for (int unsigned i = 0; i < 256; i++) begin
      r[i] = curve_entry(i, f);
    end
    return r;
  endfunction

endpackage

/* rtl/srgbxy_lin.sv */
module srgbxy_lin #(
  parameter int unsigned LinFracBits = srgbxy_pkg::LinFracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [2:0][7:0]           rgb_i,
  output logic                      valid_o,
  output logic [2:0][LinFracBits:0] lin_o
);

  localparam int unsigned LinW = LinFracBits + 1;
  localparam srgbxy_pkg::rom_t LinRom = srgbxy_pkg::build_rom(LinFracBits);

  logic                valid_q;
  logic [2:0][LinW-1:0] lin_q;

  // Valid bit of the lookup stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // One table read per channel.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        lin_q[k] <= LinRom[rgb_i[k]][LinW-1:0];
      end
    end
  end

  assign valid_o = valid_q;
  assign lin_o   = lin_q;

endmodule

/* rtl/srgbxy_mtx.sv */
module srgbxy_mtx #(
  parameter int unsigned LinFracBits = srgbxy_pkg::LinFracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [2:0][LinFracBits:0] lin_i,
  output logic                      valid_o,
  output logic                      zero_o,
  output logic [LinFracBits+36:0]   num_x_o,
  output logic [LinFracBits+36:0]   num_y_o,
  output logic [LinFracBits+21:0]   den_o
);

  localparam int unsigned LinW  = LinFracBits + 1;
  localparam int unsigned ProdW = LinW + 16;
  localparam int unsigned TriW  = LinW + 18;
  localparam int unsigned SumW  = TriW + 2;
  localparam int unsigned NumW  = TriW + 18;
  localparam int unsigned DenW  = SumW + 1;

  logic [2:0]                  valid_q;
  logic [2:0][2:0][ProdW-1:0]  prod_q;
  logic [2:0][TriW-1:0]        tri_d, tri_q;
  logic [SumW-1:0]             sum_d;
  logic [NumW-1:0]             num_x_q, num_y_q;
  logic [DenW-1:0]             den_q;
  logic                        zero_q;

  // Valid bits of the three matrix stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // Row sums of the registered products, and the total of the registered row sums.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tri_d[r] = TriW'(prod_q[r][0]) + TriW'(prod_q[r][1]) + TriW'(prod_q[r][2]);
    end
    sum_d = SumW'(tri_q[0]) + SumW'(tri_q[1]) + SumW'(tri_q[2]);
  end

  // Products, then row sums, then the rounded-division operands.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= ProdW'(lin_i[c]) * ProdW'(srgbxy_pkg::Coef[r][c]);
        end
      end
      tri_q   <= tri_d;
      // Numerator 2*65535*part + sum, denominator 2*sum.
      num_x_q <= (NumW'(tri_q[0]) << 17) - (NumW'(tri_q[0]) << 1) + NumW'(sum_d);
      num_y_q <= (NumW'(tri_q[1]) << 17) - (NumW'(tri_q[1]) << 1) + NumW'(sum_d);
      den_q   <= {sum_d, 1'b0};
      zero_q  <= (sum_d == '0);
    end
  end

  assign valid_o = valid_q[2];
  assign zero_o  = zero_q;
  assign num_x_o = num_x_q;
  assign num_y_o = num_y_q;
  assign den_o   = den_q;

endmodule

/* rtl/srgbxy_div.sv */
module srgbxy_div #(
  parameter int unsigned LinFracBits = srgbxy_pkg::LinFracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic                                zero_i,
  input  logic [LinFracBits+36:0]             num_x_i,
  input  logic [LinFracBits+36:0]             num_y_i,
  input  logic [LinFracBits+21:0]             den_i,
  output logic                                valid_o,
  output logic                                zero_o,
  output logic [srgbxy_pkg::QuoBits-1:0]      quo_x_o,
  output logic [srgbxy_pkg::QuoBits-1:0]      quo_y_o
);

  localparam int unsigned QB   = srgbxy_pkg::QuoBits;
  localparam int unsigned NumW = LinFracBits + 37;
  localparam int unsigned DenW = LinFracBits + 22;
  localparam int unsigned CmpW = NumW + 1;

  logic [QB-1:0]   valid_q;
  logic [QB-1:0]   zero_q;
  logic [CmpW-1:0] rem_x_q [QB];
  logic [CmpW-1:0] rem_y_q [QB];
  logic [DenW-1:0] den_q   [QB];
  logic [QB-1:0]   quo_x_q [QB];
  logic [QB-1:0]   quo_y_q [QB];

  // One quotient bit per stage, most significant first.
  for (genvar s = 0; s < QB; s++) begin : g_stg
    localparam int unsigned Sh = QB - 1 - s;
    logic [CmpW-1:0] rx, ry, dsh, rem_x_d, rem_y_d;
    logic [DenW-1:0] dn;
    logic [QB-1:0]   qx, qy;
    logic            vin, zin, gex, gey;

    if (s == 0) begin : g_first
      assign rx  = CmpW'(num_x_i);
      assign ry  = CmpW'(num_y_i);
      assign dn  = den_i;
      assign qx  = '0;
      assign qy  = '0;
      assign vin = valid_i;
      assign zin = zero_i;
    end else begin : g_next
      assign rx  = rem_x_q[s-1];
      assign ry  = rem_y_q[s-1];
      assign dn  = den_q[s-1];
      assign qx  = quo_x_q[s-1];
      assign qy  = quo_y_q[s-1];
      assign vin = valid_q[s-1];
      assign zin = zero_q[s-1];
    end

    // Trial subtract of the shifted divisor.
    assign dsh     = CmpW'(dn) << Sh;
    assign gex     = (rx >= dsh);
    assign gey     = (ry >= dsh);
    assign rem_x_d = gex ? (rx - dsh) : rx;
    assign rem_y_d = gey ? (ry - dsh) : ry;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_x_q[s] <= rem_x_d;
        rem_y_q[s] <= rem_y_d;
        den_q[s]   <= dn;
        quo_x_q[s] <= {qx[QB-2:0], gex};
        quo_y_q[s] <= {qy[QB-2:0], gey};
        zero_q[s]  <= zin;
      end
    end
  end

  assign valid_o = valid_q[QB-1];
  assign zero_o  = zero_q[QB-1];
  assign quo_x_o = quo_x_q[QB-1];
  assign quo_y_o = quo_y_q[QB-1];

endmodule

/* rtl/srgb_to_cie_xy_chromaticity_unit.sv */
// sRGB to CIE 1931 xy chromaticity (D65 white point), one pixel per beat.
// Input channel: s_axis_tvalid_i/s_axis_tready_o/s_axis_tdata_i carries one
// pixel as red, green and blue, 8 bits each. Output channel:
// m_axis_tvalid_o/m_axis_tready_i/m_axis_tdata_o carries x and y as 16-bit
// fractions scaled by 65535, rounded half up and saturated.
// A pure black pixel gives the D65 white point.
// From an accepted input beat to its output beat, the linearization table
// register takes the beat at its accepting edge, then three matrix and
// division-operand stages, 17 restoring divider stages (one quotient bit
// each) and the output register follow.
// Throughput is one pixel per cycle while the receiver does not stall.
// All stages advance together; when the receiver stalls with a beat held
// in the output register, the whole pipeline freezes and s_axis_tready_o
// drops, so nothing is lost or repeated. Empty stages do not collapse.
// Reset clears all valid bits; the output is idle right after reset and
// no clearing pass is needed.
module srgb_to_cie_xy_chromaticity_unit #(
  parameter int unsigned LinFracBits = srgbxy_pkg::LinFracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // x_chroma [15:0], y_chroma [31:16]
);

  localparam int unsigned QB = srgbxy_pkg::QuoBits;

  logic                      en;
  logic                      lin_valid, mtx_valid, mtx_zero, div_valid, div_zero;
  logic [2:0][LinFracBits:0] lin;
  logic [LinFracBits+36:0]   num_x, num_y;
  logic [LinFracBits+21:0]   den;
  logic [QB-1:0]             quo_x, quo_y;
  logic                      out_valid_q;
  logic [15:0]               x_d, y_d, x_q, y_q;

  // The pipeline moves whenever the output register is free or drained.
  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  srgbxy_lin #(.LinFracBits(LinFracBits)) u_lin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .rgb_i   ({s_axis_tdata_i[23:16], s_axis_tdata_i[15:8], s_axis_tdata_i[7:0]}),
    .valid_o (lin_valid),
    .lin_o   (lin)
  );

  srgbxy_mtx #(.LinFracBits(LinFracBits)) u_mtx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (lin_valid),
    .lin_i   (lin),
    .valid_o (mtx_valid),
    .zero_o  (mtx_zero),
    .num_x_o (num_x),
    .num_y_o (num_y),
    .den_o   (den)
  );

  srgbxy_div #(.LinFracBits(LinFracBits)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mtx_valid),
    .zero_i  (mtx_zero),
    .num_x_i (num_x),
    .num_y_i (num_y),
    .den_i   (den),
    .valid_o (div_valid),
    .zero_o  (div_zero),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y)
  );

  // Saturate the quotients and substitute the white point for black.
  always_comb begin
    x_d = quo_x[QB-1] ? srgbxy_pkg::ChromaMax : quo_x[15:0];
    y_d = quo_y[QB-1] ? srgbxy_pkg::ChromaMax : quo_y[15:0];
    if (div_zero) begin
      x_d = srgbxy_pkg::WhiteX;
      y_d = srgbxy_pkg::WhiteY;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {y_q, x_q};

endmodule

/* rtl/srgbxy_chk.sv */
`include "srgb_to_cie_xy_chromaticity_unit_assert.svh"

module srgbxy_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  logic [16:0] xy_sum;
  assign xy_sum = {1'b0, m_axis_tdata_o[15:0]} + {1'b0, m_axis_tdata_o[31:16]};

  // A held output beat stays put until taken.
  `SXY_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))
  // With the output register empty, the input side must be open.
  `SXY_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid_o, s_axis_tready_o)
  // A stalled output must back-pressure the input.
  `SXY_ASSERT_NOW(a_stall_blocks, m_axis_tvalid_o && !m_axis_tready_i, !s_axis_tready_o)
  // x plus y never exceeds one, allowing for rounding.
  `SXY_ASSERT_NOW(a_xy_bound, m_axis_tvalid_o, xy_sum <= 17'd65536)

endmodule

bind srgb_to_cie_xy_chromaticity_unit srgbxy_chk u_srgbxy_chk (.*);
